@@ hw/rtl/whc_pkg.sv @@
`timescale 1ns / 1ps

package whc_pkg;

   localparam int WINDOW  = 300;
   localparam int IDX_W   = $clog2(WINDOW);
   localparam int TIME_W  = 31;
   localparam int COUNT_W = 16;
   localparam int HITS_W  = 25;
   localparam int ENTRY_W = TIME_W + COUNT_W;

   // The bucket index is the timestamp modulo WINDOW, found through a rounded-up reciprocal.
   localparam int RECIP_SHIFT = TIME_W + IDX_W;
   localparam int QUOT_W      = TIME_W + 1 - IDX_W;
   localparam logic [TIME_W:0] RECIP = (TIME_W + 1)'(((longint'(1) << RECIP_SHIFT) +
                                        longint'(WINDOW) - 1) / longint'(WINDOW));

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [HITS_W-1:0]  HITS_MAX  = '1;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef struct packed {
      logic load;
      logic clear_step;
      logic mod_step;
      logic wr_bucket;
      logic scan_step;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic addr_last;
      logic mod_last;
      logic rsp_valid;
   } status_type;

endpackage

@@ hw/rtl/whc_ctrl.sv @@
`timescale 1ns / 1ps

module whc_ctrl import whc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_opcode,
   output logic       req_ready,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_MOD    = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_WRITE  = 3'd4;
   localparam logic [2:0] S_SCAN   = 3'd5;
   localparam logic [2:0] S_DRAIN  = 3'd6;
   localparam logic [2:0] S_RESULT = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.addr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_opcode == OP_QUERY) ? S_SCAN : S_MOD;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_last) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.wr_bucket = 1'b1;
            state_in      = S_IDLE;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.addr_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!status.rsp_valid || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/whc_datapath.sv @@
`timescale 1ns / 1ps

module whc_datapath import whc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [TIME_W-1:0]   req_time_seconds,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [HITS_W-1:0]   rsp_window_hits,
   input  cmd_type             cmd,
   output status_type          status
);

   logic [ENTRY_W-1:0] mem [WINDOW];

   logic [TIME_W-1:0]  time_ff;
   logic               mod_phase_ff;
   logic [QUOT_W-1:0]  quot_ff;
   logic [IDX_W-1:0]   rem_ff;
   logic [IDX_W-1:0]   rem_in;
   logic [2*TIME_W:0]  product;
   logic [IDX_W-1:0]   addr_ff;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               acc_en_ff;
   logic [HITS_W-1:0]  acc_ff;
   logic [HITS_W:0]    sum;
   logic               rsp_valid_ff;
   logic [HITS_W-1:0]  rsp_hits_ff;

   logic [TIME_W-1:0]  rd_second;
   logic [COUNT_W-1:0] rd_count;
   logic [TIME_W:0]    age;
   logic               in_window;
   logic [COUNT_W-1:0] new_count;
   logic [ENTRY_W-1:0] wr_data;
   logic [IDX_W-1:0]   wr_addr;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;

   // The quotient by WINDOW is registered first and the remainder follows in the cycle after.
   assign product = {{(TIME_W + 1){1'b0}}, time_ff} * {{TIME_W{1'b0}}, RECIP};
   assign rem_in  = time_ff[IDX_W-1:0] - IDX_W'(quot_ff * QUOT_W'(WINDOW));

   assign rd_second = rd_data_ff[ENTRY_W-1:COUNT_W];
   assign rd_count  = rd_data_ff[COUNT_W-1:0];
   assign age       = {1'b0, time_ff} - {1'b0, rd_second};
   assign in_window = $signed(age) < $signed((TIME_W + 1)'(WINDOW));
   assign sum       = {1'b0, acc_ff} + (HITS_W + 1)'(in_window ? rd_count : '0);

   always_comb begin
      if (rd_second == time_ff) begin
         new_count = (rd_count == COUNT_MAX) ? rd_count : rd_count + 1'b1;
      end else begin
         new_count = COUNT_W'(1);
      end
   end

   assign wr_en   = cmd.clear_step || cmd.wr_bucket;
   assign wr_addr = cmd.clear_step ? addr_ff : rem_ff;
   assign wr_data = cmd.clear_step ? '0 : {time_ff, new_count};
   assign rd_addr = cmd.scan_step ? addr_ff : rem_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         time_ff      <= req_time_seconds;
         mod_phase_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         if (cmd.mod_step) begin
            if (!mod_phase_ff) begin
               quot_ff <= product[RECIP_SHIFT +: QUOT_W];
            end else begin
               rem_ff <= rem_in;
            end
            mod_phase_ff <= 1'b1;
         end
         if (acc_en_ff) begin
            acc_ff <= sum[HITS_W] ? HITS_MAX : sum[HITS_W-1:0];
         end
      end
      if (cmd.rsp_load) begin
         rsp_hits_ff <= acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         acc_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_en_ff <= cmd.scan_step;
         if (cmd.clear_step || cmd.scan_step) begin
            addr_ff <= status.addr_last ? '0 : addr_ff + 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.addr_last = (addr_ff == IDX_W'(WINDOW - 1));
   assign status.mod_last  = mod_phase_ff;
   assign status.rsp_valid = rsp_valid_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_window_hits = rsp_hits_ff;

endmodule

@@ hw/rtl/windowed_hit_counter.sv @@
`timescale 1ns / 1ps
// Sliding-window hit counter over a ring of per-second buckets.
// The request channel takes one word per item: opcode 0 records a hit at
// req_time_seconds, opcode 1 asks how many hits fall in the window that ends
// at req_time_seconds. Only a query produces a response word, on rsp_*.
// A record reduces the timestamp to a bucket index with a reciprocal
// multiplication, first the quotient and then the remainder, and then does
// one bucket read and one bucket write before the next word can be taken.
// A query walks every bucket, one memory read per cycle, so its response is
// loaded once the walk is done and the next word is taken right after.
// Only one request is in progress at a time.
// After reset the bucket memory is cleared one entry per cycle; req_ready
// stays low until the clear pass has finished.
// The response sits in an output register. A stalled receiver does not block
// records, but a query that finishes while the previous response is still
// waiting holds until that response is taken.

module windowed_hit_counter import whc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_opcode,
   input  logic [TIME_W-1:0] req_time_seconds,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [HITS_W-1:0] rsp_window_hits
);

   cmd_type    cmd;
   status_type status;

   whc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   whc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_time_seconds (req_time_seconds),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_window_hits  (rsp_window_hits),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

@@ hw/rtl/whc_checker.sv @@
`timescale 1ns / 1ps

module whc_checker import whc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_opcode,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [HITS_W-1:0] rsp_window_hits
);

   localparam logic [HITS_W:0] HITS_BOUND = ((WINDOW * 65535) > int'(HITS_MAX)) ?
                                            (HITS_W + 1)'(HITS_MAX) :
                                            (HITS_W + 1)'(WINDOW * 65535);

   // A response word that is not taken stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_window_hits))
      else $error("response word changed while stalled");

   // The clear pass keeps the request side closed right after reset.
   assert property (@(posedge clock) reset |=> !req_ready && !rsp_valid)
      else $error("block ready or responding during clear pass");

   // Only one word is in progress at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new word taken while the previous one is in progress");

   // No window can hold more hits than every bucket full.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_window_hits} <= HITS_BOUND)
      else $error("window hit count out of range");

   // A record word never produces a response on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == OP_RECORD) && !rsp_valid |=> !rsp_valid)
      else $error("response appeared after a record word");

endmodule

bind windowed_hit_counter whc_checker u_whc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_opcode       (req_opcode),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_window_hits  (rsp_window_hits)
);

@@ test/windowed_hit_counter_checker.sv @@
`timescale 1ns / 1ps

module windowed_hit_counter_checker import whc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_opcode,
   input  logic [TIME_W-1:0] req_time_seconds,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [HITS_W-1:0] rsp_window_hits,
   output int                failures,
   output int                open_queries
);

   logic [TIME_W-1:0]  slot_second [WINDOW];
   logic [COUNT_W-1:0] slot_hits [WINDOW];
   logic [HITS_W-1:0]  expected_hits [$];

   always @(posedge clock) begin : watch
      int idx;
      longint query_time;
      longint stored;
      longint total;
      logic [HITS_W-1:0] want;
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            slot_second[i] = '0;
            slot_hits[i] = '0;
         end
         expected_hits.delete();
         failures <= 0;
         open_queries <= 0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_opcode == OP_RECORD) begin
               idx = int'(req_time_seconds % WINDOW);
               if (slot_second[idx] == req_time_seconds) begin
                  if (slot_hits[idx] != COUNT_MAX) begin
                     slot_hits[idx] = slot_hits[idx] + 1'b1;
                  end
               end else begin
                  slot_second[idx] = req_time_seconds;
                  slot_hits[idx] = COUNT_W'(1);
               end
            end else begin
               // The age is signed, so a bucket written later than the query counts.
               query_time = longint'(req_time_seconds);
               total = 0;
               for (int i = 0; i < WINDOW; i++) begin
                  stored = longint'(slot_second[i]);
                  if (query_time - stored < longint'(WINDOW)) begin
                     total = total + longint'(slot_hits[i]);
                  end
               end
               if (total > longint'(HITS_MAX)) begin
                  total = longint'(HITS_MAX);
               end
               expected_hits.push_back(total[HITS_W-1:0]);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_hits.size() == 0) begin
               $error("window_hits: expected none, actual %0d", rsp_window_hits);
               failures <= failures + 1;
            end else begin
               want = expected_hits.pop_front();
               if (rsp_window_hits !== want) begin
                  $error("window_hits: expected %0d, actual %0d", want, rsp_window_hits);
                  failures <= failures + 1;
               end
            end
         end
         open_queries <= expected_hits.size();
      end
   end

endmodule

@@ test/windowed_hit_counter_test.sv @@
`timescale 1ns / 1ps

module windowed_hit_counter_test;
   import whc_pkg::*;

   localparam longint TIME_TOP     = (longint'(1) << TIME_W) - 1;
   localparam int     HOLD_CYCLES  = 1500;
   localparam int     STALL_LIMIT  = 8000;
   localparam int     DRAIN_CYCLES = 400;
   localparam int     RANDOM_WORDS = 680;
   localparam int     CALM_TAIL    = 100;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_opcode = OP_RECORD;
   logic [TIME_W-1:0] req_time_seconds = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [HITS_W-1:0] rsp_window_hits;

   int failures;
   int open_queries;
   int quiet_cycles = 0;
   bit sender_idling = 1'b1;
   bit receiver_idling = 1'b1;
   bit hold_due = 1'b0;

   always #6 clock = ~clock;

   windowed_hit_counter i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_time_seconds (req_time_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_window_hits  (rsp_window_hits)
   );

   windowed_hit_counter_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_time_seconds (req_time_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_window_hits  (rsp_window_hits),
      .failures         (failures),
      .open_queries     (open_queries)
   );

   task automatic send_word(input logic op, input logic [TIME_W-1:0] t);
      if (sender_idling && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_time_seconds <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   initial begin : stimulus
      longint cursor;
      longint t;
      int step;
      int back;
      int left;
      int n;
      int r;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Cleared buckets hold second zero, so a hit at second zero joins them.
      send_word(OP_QUERY, 0);
      send_word(OP_RECORD, 0);
      send_word(OP_RECORD, 0);
      send_word(OP_QUERY, 0);
      send_word(OP_RECORD, 1);
      send_word(OP_RECORD, 299);
      send_word(OP_QUERY, 299);
      send_word(OP_QUERY, 300);
      send_word(OP_RECORD, 300);
      send_word(OP_QUERY, 599);
      send_word(OP_RECORD, 598);
      send_word(OP_QUERY, 897);
      send_word(OP_QUERY, 898);
      send_word(OP_RECORD, TIME_TOP[TIME_W-1:0]);
      send_word(OP_RECORD, TIME_TOP[TIME_W-1:0]);
      send_word(OP_QUERY, TIME_TOP[TIME_W-1:0]);
      // Going back in time: negative ages count, and an older hit overwrites.
      send_word(OP_RECORD, 5);
      send_word(OP_QUERY, 5);
      send_word(OP_RECORD, TIME_TOP[TIME_W-1:0] - 300);
      send_word(OP_QUERY, TIME_TOP[TIME_W-1:0] - 300);
      send_word(OP_RECORD, 31'h2AAAAAAA);
      send_word(OP_QUERY, 31'h2AAAAAAA);
      send_word(OP_RECORD, 31'h55555555);
      send_word(OP_QUERY, 31'h55555555);

      cursor = 0;
      n = 0;
      left = 0;
      while (n < RANDOM_WORDS) begin
         if (left == 0) begin
            left = $urandom_range(10, 40);
            sender_idling = (n < RANDOM_WORDS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            receiver_idling = (n < RANDOM_WORDS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 7))
               0, 1: cursor = $urandom() & TIME_TOP;
               2: cursor = TIME_TOP - $urandom_range(0, 3000);
               3: cursor = $urandom_range(0, 1000);
               default: cursor = cursor + $urandom_range(0, 700);
            endcase
         end
         if (n == RANDOM_WORDS / 2) begin
            hold_due = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 60) begin
            step = 0;
         end else if (r < 90) begin
            step = $urandom_range(1, 3);
         end else if (r < 98) begin
            step = $urandom_range(4, 50);
         end else begin
            step = $urandom_range(250, 350);
         end
         cursor = cursor + step;
         if (cursor > TIME_TOP) begin
            cursor = TIME_TOP;
         end
         t = cursor;
         if ($urandom_range(0, 29) == 0) begin
            back = $urandom_range(1, 400);
            t = cursor - back;
            if (t < 0) begin
               t = 0;
            end
         end
         send_word(($urandom_range(0, 3) == 0) ? OP_QUERY : OP_RECORD, t[TIME_W-1:0]);
         n++;
         left--;
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (open_queries != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("windowed_hit_counter_test: PASS");
      end else begin
         $display("windowed_hit_counter_test: FAIL");
      end
      $finish;
   end

   initial begin : receiver
      wait (!reset);
      forever begin
         if (hold_due) begin
            hold_due = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("windowed_hit_counter_test: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
